// ===== hw/rtl/ttst_pkg.sv =====
`timescale 1ns / 1ps
// Tab-stop table package: sizes, operation codes, result type and default stop pattern.
// No dependencies.
package ttst_pkg;

	localparam int MaxColumns     = 256;
	localparam int DefaultColumns = 80;
	localparam int TabPeriod      = 8;
	localparam int ColW           = $clog2(MaxColumns);
	localparam int WidthW         = $clog2(MaxColumns + 1);

	typedef enum logic [2:0] {
		OpDefaults  = 3'd0,
		OpSet       = 3'd1,
		OpClear     = 3'd2,
		OpClearAll  = 3'd3,
		OpFindRight = 3'd4,
		OpFindLeft  = 3'd5,
		OpResize    = 3'd6
	} op_t;

	typedef struct packed {
		logic            found;
		logic [ColW-1:0] stop_column;
	} find_res_t;

	function automatic logic [MaxColumns-1:0] default_stops();
		logic [MaxColumns-1:0] v;
		v = '0;
		for (int i = 0; i < MaxColumns; i++) begin
			v[i] = ((i % TabPeriod) == 0);
		end
		return v;
	endfunction

	localparam logic [MaxColumns-1:0] DefaultStops = default_stops();

	localparam logic [WidthW-1:0] ResetWidth =
		(DefaultColumns < 1) ? WidthW'(1) :
		(DefaultColumns > MaxColumns) ? WidthW'(MaxColumns) : WidthW'(DefaultColumns);

endpackage

// ===== hw/rtl/ttst_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the tab-stop table.
// Depends on ttst_pkg.
interface ttst_req_if import ttst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        operation;
	logic [ColW-1:0]   column;
	logic [WidthW-1:0] new_width;

	modport source (output valid, output operation, output column, output new_width,
		input ready);
	modport sink (input valid, input operation, input column, input new_width,
		output ready);
endinterface

interface ttst_rsp_if import ttst_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            found;
	logic [ColW-1:0] stop_column;

	modport source (output valid, output found, output stop_column, input ready);
	modport sink (input valid, input found, input stop_column, output ready);
endinterface

// ===== hw/rtl/ttst_find.sv =====
`timescale 1ns / 1ps
// Masked priority search for the nearest tab stop right or left of a column.
// Depends on ttst_pkg.
module ttst_find import ttst_pkg::*; (
	input  op_t                   op,
	input  logic [ColW-1:0]       column,
	input  logic [WidthW-1:0]     width,
	input  logic [MaxColumns-1:0] stops,
	output find_res_t             res
);

	logic [WidthW-1:0] col_w;
	logic              left_ok;

	assign col_w   = WidthW'(column);
	assign left_ok = (column != '0) && ((col_w - WidthW'(1)) < width);

	always_comb begin
		res = '0;
		case (op)
			OpFindRight: begin
				// scan downward so the lowest qualifying stop wins
				for (int i = MaxColumns - 1; i >= 0; i--) begin
					if (stops[i] && (WidthW'(i) > col_w) && (WidthW'(i) < width)) begin
						res.found       = 1'b1;
						res.stop_column = ColW'(i);
					end
				end
			end
			OpFindLeft: begin
				// scan upward so the highest qualifying stop wins
				for (int i = 0; i < MaxColumns; i++) begin
					if (left_ok && stops[i] && (WidthW'(i) < col_w)) begin
						res.found       = 1'b1;
						res.stop_column = ColW'(i);
					end
				end
			end
			default: res = '0;
		endcase
	end

endmodule

// ===== hw/rtl/terminal_tab_stop_table_core.sv =====
`timescale 1ns / 1ps
// Tab-stop table: one stop bit per column plus the column count in use.
// Stages: input register, then result register; the response comes from the result register.
// Throughput: one item per cycle unless the response stalls; stops update when the result loads.
// Reset: stops at every eighth column, 80 columns in use, both stages empty.
// Depends on ttst_pkg, ttst_if and ttst_find.
module terminal_tab_stop_table_core import ttst_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	ttst_req_if.sink   req,
	ttst_rsp_if.source rsp
);

	logic                  valid_s1;
	op_t                   op_s1;
	logic [ColW-1:0]       column_s1;
	logic [WidthW-1:0]     new_width_s1;

	logic [MaxColumns-1:0] stops_q;
	logic [WidthW-1:0]     width_q;

	logic                  out_valid_q;
	find_res_t             out_res_q;

	logic                  advance;
	logic [MaxColumns-1:0] stops_d;
	logic [WidthW-1:0]     width_d;
	logic [WidthW-1:0]     nw_clamped;
	logic [WidthW-1:0]     col_w;
	find_res_t             find_res;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	assign col_w = WidthW'(column_s1);

	assign nw_clamped = (new_width_s1 == '0) ? WidthW'(1) :
		(new_width_s1 > WidthW'(MaxColumns)) ? WidthW'(MaxColumns) : new_width_s1;

	ttst_find u_find (
		.op     (op_s1),
		.column (column_s1),
		.width  (width_q),
		.stops  (stops_q),
		.res    (find_res)
	);

	always_comb begin
		stops_d = stops_q;
		width_d = width_q;
		case (op_s1)
			OpDefaults: stops_d = DefaultStops;
			OpSet: begin
				if ((column_s1 != '0) && (col_w < width_q)) begin
					stops_d[column_s1] = 1'b1;
				end
			end
			OpClear: begin
				if (col_w < width_q) begin
					stops_d[column_s1] = 1'b0;
				end else begin
					stops_d[0] = 1'b0;
				end
			end
			OpClearAll: stops_d = '0;
			OpResize: begin
				for (int i = 0; i < MaxColumns; i++) begin
					if ((WidthW'(i) >= width_q) && (WidthW'(i) < nw_clamped)) begin
						stops_d[i] = DefaultStops[i];
					end
				end
				width_d = nw_clamped;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			stops_q     <= DefaultStops;
			width_q     <= ResetWidth;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				stops_q     <= stops_d;
				width_q     <= width_d;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1        <= op_t'(req.operation);
			column_s1    <= req.column;
			new_width_s1 <= req.new_width;
		end
		if (advance) begin
			out_res_q <= find_res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = out_res_q.found;
	assign rsp.stop_column = out_res_q.stop_column;

`ifndef SYNTHESIS
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		(width_q != '0) && (width_q <= WidthW'(MaxColumns)))
		else $error("column count out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && out_valid_q && !rsp.ready))
		else $error("request stalled with room in the pipeline");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_res_q.found) |-> (out_res_q.stop_column == '0))
		else $error("stop column nonzero without a found stop");

	a_found_in_width: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && find_res.found) |-> (WidthW'(find_res.stop_column) < width_q))
		else $error("found stop beyond the columns in use");
`endif

endmodule

// ===== dv/tab_stop_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the tab-stop table: predicts each result from accepted requests and checks it.
// Depends on ttst_pkg.
package tab_stop_scoreboard_pkg;
	import ttst_pkg::*;

	localparam logic [2:0] OpNone = 3'd7;

	class tab_stop_scoreboard;
		logic [MaxColumns-1:0] stops;
		int                    width;
		find_res_t             expected_q[$];
		int unsigned           errors;

		function new();
			errors = 0;
			restore_stops();
			width = fit_width(DefaultColumns);
		endfunction

		function void restore_stops();
			for (int i = 0; i < MaxColumns; i++) begin
				stops[i] = ((i % TabPeriod) == 0);
			end
		endfunction

		function int fit_width(int w);
			if (w < 1) begin
				return 1;
			end
			if (w > MaxColumns) begin
				return MaxColumns;
			end
			return w;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void report(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endfunction

		function void note_request(logic [2:0] op, logic [ColW-1:0] col, logic [WidthW-1:0] nw);
			find_res_t r;
			int        c;
			int        w;
			r = '0;
			c = int'(col);
			case (op)
				OpDefaults: restore_stops();
				OpSet: begin
					if (c > 0 && c < width) begin
						stops[c] = 1'b1;
					end
				end
				OpClear: stops[(c < width) ? c : 0] = 1'b0;
				OpClearAll: stops = '0;
				OpFindRight: begin
					for (int i = c + 1; i < width && !r.found; i++) begin
						if (stops[i]) begin
							r.found = 1'b1;
							r.stop_column = ColW'(i);
						end
					end
				end
				OpFindLeft: begin
					if (c > 0 && c - 1 < width) begin
						for (int i = c - 1; i >= 0 && !r.found; i--) begin
							if (stops[i]) begin
								r.found = 1'b1;
								r.stop_column = ColW'(i);
							end
						end
					end
				end
				OpResize: begin
					w = fit_width(int'(nw));
					for (int i = width; i < w; i++) begin
						stops[i] = ((i % TabPeriod) == 0);
					end
					width = w;
				end
				default: ;
			endcase
			expected_q = {expected_q, r};
		endfunction

		function void check_result(logic found, logic [ColW-1:0] stop_column);
			find_res_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("result found=%0b stop_column=%0d with nothing expected",
					found, stop_column));
				return;
			end
			e = expected_q.pop_front();
			if (found !== e.found) begin
				report($sformatf("found %0b, expected %0b", found, e.found));
			end
			if (stop_column !== e.stop_column) begin
				report($sformatf("stop_column %0d, expected %0d", stop_column, e.stop_column));
			end
		endfunction
	endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for terminal_tab_stop_table_core: directed and random requests with random stalls.
// Depends on ttst_pkg, ttst_if, tab_stop_scoreboard_pkg and the core RTL.
module tb_top;
	import ttst_pkg::*;
	import tab_stop_scoreboard_pkg::*;

	localparam int RandomItems = 1050;
	localparam int CycleLimit  = 200000;

	logic clk;
	logic arst_n;
	bit   calm;

	ttst_req_if req_if ();
	ttst_rsp_if rsp_if ();

	tab_stop_scoreboard sb = new();

	terminal_tab_stop_table_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				sb.note_request(req_if.operation, req_if.column, req_if.new_width);
			end
			if (rsp_if.valid && rsp_if.ready) begin
				sb.check_result(rsp_if.found, rsp_if.stop_column);
			end
		end
	end

	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_if.ready <= arst_n && (calm || $urandom_range(99) >= 18);
		end
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("terminal_tab_stop_table_core test failed");
		$finish;
	end

	task automatic send_item(input logic [2:0] op, input logic [ColW-1:0] col,
		input logic [WidthW-1:0] nw);
		while (!calm && $urandom_range(99) < 18) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.operation <= op;
		req_if.column    <= col;
		req_if.new_width <= nw;
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic wait_drained();
		while (sb.outstanding() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic send_random_item();
		int unsigned     pick;
		int              c;
		logic [2:0]      op;
		logic [WidthW-1:0] nw;
		pick = $urandom_range(99);
		if (pick < 3) begin
			op = OpDefaults;
		end else if (pick < 23) begin
			op = OpSet;
		end else if (pick < 38) begin
			op = OpClear;
		end else if (pick < 40) begin
			op = OpClearAll;
		end else if (pick < 67) begin
			op = OpFindRight;
		end else if (pick < 92) begin
			op = OpFindLeft;
		end else if (pick < 98) begin
			op = OpResize;
		end else begin
			op = OpNone;
		end
		if ($urandom_range(99) < 70) begin
			c = $urandom_range(255);
		end else begin
			c = sb.width + int'($urandom_range(3)) - 2;
			c = (c < 0) ? 0 : (c > 255) ? 255 : c;
		end
		pick = $urandom_range(99);
		if (op != OpResize) begin
			nw = WidthW'($urandom_range(511));
		end else if (pick < 10) begin
			nw = '0;
		end else if (pick < 20) begin
			nw = WidthW'($urandom_range(511, 257));
		end else if (pick < 40) begin
			nw = WidthW'($urandom_range(16, 1));
		end else begin
			nw = WidthW'($urandom_range(256, 1));
		end
		send_item(op, ColW'(c), nw);
	endtask

	initial begin
		arst_n           <= 1'b0;
		calm             = 1'b0;
		req_if.valid     <= 1'b0;
		req_if.operation <= OpDefaults;
		req_if.column    <= '0;
		req_if.new_width <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OpFindRight, 8'd0, 9'd0);
		send_item(OpFindLeft, 8'd255, 9'd511);
		send_item(OpFindLeft, 8'd0, 9'd0);
		send_item(OpFindLeft, 8'd80, 9'd0);
		send_item(OpFindRight, 8'd79, 9'd0);
		send_item(OpSet, 8'd0, 9'd0);
		send_item(OpSet, 8'd79, 9'd0);
		send_item(OpSet, 8'd80, 9'd0);
		send_item(OpFindRight, 8'd78, 9'd0);
		send_item(OpClear, 8'd200, 9'd0);
		send_item(OpFindLeft, 8'd1, 9'd0);
		send_item(OpClear, 8'd8, 9'd0);
		send_item(OpResize, 8'd0, 9'd0);
		send_item(OpFindRight, 8'd0, 9'd0);
		send_item(OpResize, 8'd255, 9'd511);
		send_item(OpFindLeft, 8'd255, 9'd0);
		send_item(OpSet, 8'd255, 9'd0);
		send_item(OpFindRight, 8'd254, 9'd0);
		send_item(OpResize, 8'd0, 9'd40);
		send_item(OpClear, 8'd48, 9'd0);
		send_item(OpResize, 8'd0, 9'd256);
		send_item(OpFindLeft, 8'd100, 9'd0);
		send_item(OpClearAll, 8'd0, 9'd0);
		send_item(OpFindRight, 8'd0, 9'd0);
		send_item(OpNone, 8'd255, 9'd511);
		send_item(OpDefaults, 8'd0, 9'd0);

		for (int n = 0; n < RandomItems; n++) begin
			calm = (n >= 400 && n < 600);
			if (n == 700) begin
				req_if.valid <= 1'b0;
				@(posedge clk);
				wait_drained();
			end
			send_random_item();
		end
		calm = 1'b0;
		req_if.valid <= 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("terminal_tab_stop_table_core test passed");
		end else begin
			$display("terminal_tab_stop_table_core test failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/ttst_pkg.sv
hw/rtl/ttst_if.sv
hw/rtl/ttst_find.sv
hw/rtl/terminal_tab_stop_table_core.sv
dv/tab_stop_scoreboard_pkg.sv
dv/tb_top.sv
